/* design/rmp_pkg.sv */
// ----------------------------------------------------------------------------
// rmp_pkg: shared types and constants for the ragged matrix permanent
// Data width and the result bundle that the search engine returns to the
// top level.
// ----------------------------------------------------------------------------
package rmp_pkg;

   localparam int DATA_W = 32;

   // search engine -> top level
   typedef struct packed {
      logic              done;   // one-cycle pulse, sum is final
      logic [DATA_W-1:0] sum;    // wrapped sum of products
   } srch_res_type;

endpackage

/* design/rmp_search.sv */
// ----------------------------------------------------------------------------
// rmp_search: depth-first permanent search over the stored ragged matrix
// Holds the element memory, walks every distinct-column choice with a
// column-in-use mask and a per-row stack, and accumulates the products with
// one shared 32x32 multiplier.
// ----------------------------------------------------------------------------
module rmp_search #(
   parameter int MAX_ROWS = 8,
   parameter int MAX_COLS = 8,
   parameter int RNW      = 4,   // width of a row count
   parameter int CNW      = 4,   // width of a column count
   parameter int AW       = 6    // element memory address width
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          wr_en,
   input  logic [AW-1:0]                 wr_addr,
   input  logic [rmp_pkg::DATA_W-1:0]    wr_data,
   input  logic                          start,
   input  logic [RNW-1:0]                rows,
   input  logic [MAX_ROWS*CNW-1:0]       lens_flat,
   output rmp_pkg::srch_res_type         res
);

   localparam int DEPTH = MAX_ROWS * MAX_COLS;
   localparam int RIW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CIW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_SCAN = 4'b0010,
      S_MUL  = 4'b0100,
      S_ACC  = 4'b1000
   } state_type;

   state_type                    state_ff, state_in;
   logic [RIW-1:0]               r_ff, r_in;
   logic [CNW-1:0]               c_ff, c_in;
   logic [MAX_COLS-1:0]          used_ff, used_in;
   logic [rmp_pkg::DATA_W-1:0]   sum_ff, sum_in;
   logic [rmp_pkg::DATA_W-1:0]   prod_ff;
   logic [rmp_pkg::DATA_W-1:0]   rd_q;
   logic [rmp_pkg::DATA_W-1:0]   mul_base;
   logic [AW-1:0]                rd_addr;
   logic [RIW-1:0]               prev_r;
   logic [CNW-1:0]               len_r;
   logic [CIW-1:0]               c_idx;
   logic                         last_row;
   logic                         done;

   logic [rmp_pkg::DATA_W-1:0]   mem [DEPTH];
   logic [CIW-1:0]               chosen_ff [MAX_ROWS];
   logic [rmp_pkg::DATA_W-1:0]   partial_ff [MAX_ROWS];

   // element memory: one write port from the loader, one registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_q <= mem[rd_addr];
   end

   assign c_idx    = c_ff[CIW-1:0];
   assign prev_r   = r_ff - RIW'(1);
   assign len_r    = lens_flat[r_ff*CNW +: CNW];
   assign rd_addr  = AW'(32'(r_ff) * 32'(MAX_COLS) + 32'(c_idx));
   assign mul_base = (r_ff == '0) ? rmp_pkg::DATA_W'(1) : partial_ff[prev_r];
   assign last_row = ((RNW+1)'(r_ff) + (RNW+1)'(1)) >= (RNW+1)'(rows);

   always_comb begin
      state_in = state_ff;
      r_in     = r_ff;
      c_in     = c_ff;
      used_in  = used_ff;
      sum_in   = sum_ff;
      done     = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               r_in     = '0;
               c_in     = '0;
               used_in  = '0;
               sum_in   = '0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (c_ff >= len_r) begin
               // row exhausted: pop back to the previous row
               if (r_ff == '0) begin
                  done     = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  used_in[chosen_ff[prev_r]] = 1'b0;
                  c_in = CNW'(chosen_ff[prev_r]) + CNW'(1);
                  r_in = prev_r;
               end
            end else if (used_ff[c_idx]) begin
               c_in = c_ff + CNW'(1);
            end else begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            state_in = S_ACC;
         end
         S_ACC: begin
            if (last_row) begin
               sum_in = sum_ff + prod_ff;
               c_in   = c_ff + CNW'(1);
            end else begin
               used_in[c_idx] = 1'b1;
               r_in = r_ff + RIW'(1);
               c_in = '0;
            end
            state_in = S_SCAN;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         r_ff     <= '0;
         c_ff     <= '0;
         used_ff  <= '0;
         sum_ff   <= '0;
      end else begin
         state_ff <= state_in;
         r_ff     <= r_in;
         c_ff     <= c_in;
         used_ff  <= used_in;
         sum_ff   <= sum_in;
      end
   end

   // stack and product register hold payload only
   always_ff @(posedge clock) begin
      if (state_ff == S_MUL) begin
         prod_ff <= mul_base * rd_q;
      end
      if (state_ff == S_ACC && !last_row) begin
         partial_ff[r_ff] <= prod_ff;
         chosen_ff[r_ff]  <= c_idx;
      end
   end

   assign res.done = done;
   assign res.sum  = sum_ff;

endmodule

/* design/ragged_matrix_permanent.sv */
// ----------------------------------------------------------------------------
// ragged_matrix_permanent: permanent of a zero-padded ragged matrix
// Loads rows element by element, then sums the products over every choice
// of distinct columns, one per row, wrapping to 32 bits.
//
// Channel  Dir  Ports                     Contents
// req      in   req_tdata/tlast/tuser     value / end_of_row / end_of_set
// rsp      out  rsp_tdata/tuser           sum / too_large
//
// Load items are taken one per cycle. The end-of-set item starts a search
// that steps through a scan, a multiply and an accumulate state per visited
// partial choice and a scan state per skipped or exhausted column, its pace
// set by the single shared multiplier and element memory read port.
// An oversized set skips the search. req_tready stays low from the end-of-set
// transfer until the result is in the output register. Reset is synchronous
// and clears all load counters and row lengths.
// ----------------------------------------------------------------------------
module ragged_matrix_permanent #(
   parameter int MAX_ROWS = 8,
   parameter int MAX_COLS = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [31:0]                 req_tdata,   // [31:0] value
   input  logic                        req_tlast,   // end_of_row
   input  logic                        req_tuser,   // [0] end_of_set
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [31:0]                 rsp_tdata,   // [31:0] sum
   output logic                        rsp_tuser    // [0] too_large
);

   localparam int RNW   = $clog2(MAX_ROWS + 1);
   localparam int CNW   = $clog2(MAX_COLS + 1);
   localparam int RIW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int DEPTH = MAX_ROWS * MAX_COLS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   typedef enum logic [2:0] {
      S_LOAD   = 3'b001,
      S_SEARCH = 3'b010,
      S_FINISH = 3'b100
   } state_type;

   state_type                   state_ff, state_in;
   logic [RNW-1:0]              rows_ff, rows_in;
   logic [CNW-1:0]              col_ff, col_in;
   logic                        ovf_ff, ovf_in;
   logic [CNW-1:0]              lens_ff [MAX_ROWS];
   logic [MAX_ROWS*CNW-1:0]     lens_flat;
   logic [rmp_pkg::DATA_W-1:0]  result_ff, result_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [rmp_pkg::DATA_W-1:0]  rsp_sum_ff;
   logic                        rsp_ovf_ff;
   logic                        load_out;
   logic                        accept;
   logic                        row_open;
   logic                        store_ok;
   logic [CNW-1:0]              col_inc;
   logic                        close_row;
   logic                        start;
   logic [AW-1:0]               wr_addr;
   rmp_pkg::srch_res_type       srch_res;

   assign req_tready = (state_ff == S_LOAD);
   assign accept     = req_tvalid && req_tready;
   assign row_open   = rows_ff < RNW'(MAX_ROWS);
   assign store_ok   = row_open && (col_ff < CNW'(MAX_COLS));
   assign col_inc    = (col_ff < CNW'(MAX_COLS)) ? col_ff + CNW'(1) : col_ff;
   assign close_row  = req_tlast || req_tuser;
   assign wr_addr    = AW'(32'(rows_ff[RIW-1:0]) * 32'(MAX_COLS)
                           + 32'(col_ff));
   assign load_out   = (state_ff == S_FINISH) && (!rsp_valid_ff || rsp_tready);

   for (genvar i = 0; i < MAX_ROWS; i++) begin : g_lens
      assign lens_flat[i*CNW +: CNW] = lens_ff[i];
   end

   always_comb begin
      state_in  = state_ff;
      rows_in   = rows_ff;
      col_in    = col_ff;
      ovf_in    = ovf_ff;
      result_in = result_ff;
      start     = 1'b0;
      case (state_ff)
         S_LOAD: begin
            if (accept) begin
               ovf_in = ovf_ff || !store_ok;
               if (close_row) begin
                  col_in = '0;
                  if (row_open) begin
                     rows_in = rows_ff + RNW'(1);
                  end
               end else begin
                  col_in = col_inc;
               end
               if (req_tuser) begin
                  result_in = '0;
                  if (ovf_in) begin
                     state_in = S_FINISH;
                  end else begin
                     start    = 1'b1;
                     state_in = S_SEARCH;
                  end
               end
            end
         end
         S_SEARCH: begin
            if (srch_res.done) begin
               result_in = srch_res.sum;
               state_in  = S_FINISH;
            end
         end
         S_FINISH: begin
            // wait for the output register, then clear for the next set
            if (load_out) begin
               rows_in  = '0;
               col_in   = '0;
               ovf_in   = 1'b0;
               state_in = S_LOAD;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         rows_ff      <= '0;
         col_ff       <= '0;
         ovf_ff       <= 1'b0;
         result_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_ROWS; i++) begin
            lens_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rows_ff      <= rows_in;
         col_ff       <= col_in;
         ovf_ff       <= ovf_in;
         result_ff    <= result_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept && close_row && row_open) begin
            lens_ff[rows_ff[RIW-1:0]] <= col_inc;
         end
         if (load_out) begin
            for (int i = 0; i < MAX_ROWS; i++) begin
               lens_ff[i] <= '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_sum_ff <= result_ff;
         rsp_ovf_ff <= ovf_ff;
      end
   end

   rmp_search #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS),
      .RNW      (RNW),
      .CNW      (CNW),
      .AW       (AW)
   ) u_search (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (accept && store_ok),
      .wr_addr   (wr_addr),
      .wr_data   (req_tdata),
      .start     (start),
      .rows      (rows_in),
      .lens_flat (lens_flat),
      .res       (srch_res)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_sum_ff;
   assign rsp_tuser  = rsp_ovf_ff;

endmodule
